// ----- src/s5hp_pkg.sv -----
package s5hp_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_REPLY = 2'd0;
	localparam logic [1:0] KIND_ADDR  = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	// Destination address kinds as reported on the result channel.
	localparam logic [1:0] ATYP_IPV4   = 2'd0;
	localparam logic [1:0] ATYP_DOMAIN = 2'd1;
	localparam logic [1:0] ATYP_IPV6   = 2'd2;

	// Error codes.
	localparam logic [2:0] ERR_BAD_VERSION  = 3'd0;
	localparam logic [2:0] ERR_NO_METHODS   = 3'd1;
	localparam logic [2:0] ERR_NO_AUTH      = 3'd2;
	localparam logic [2:0] ERR_BAD_REQ_VER  = 3'd3;
	localparam logic [2:0] ERR_NOT_CONNECT  = 3'd4;
	localparam logic [2:0] ERR_RSV_NONZERO  = 3'd5;
	localparam logic [2:0] ERR_BAD_ATYP     = 3'd6;
	localparam logic [2:0] ERR_EMPTY_DOMAIN = 3'd7;

	// Protocol bytes.
	localparam logic [7:0] SOCKS_VERSION  = 8'h05;
	localparam logic [7:0] METHOD_NO_AUTH = 8'h00;
	localparam logic [7:0] METHOD_NONE    = 8'hFF;
	localparam logic [7:0] CMD_CONNECT    = 8'h01;
	localparam logic [7:0] RSV_BYTE       = 8'h00;
	localparam logic [7:0] WIRE_IPV4      = 8'h01;
	localparam logic [7:0] WIRE_DOMAIN    = 8'h03;
	localparam logic [7:0] WIRE_IPV6      = 8'h04;
	localparam logic [7:0] IPV4_LEN       = 8'd4;
	localparam logic [7:0] IPV6_LEN       = 8'd16;

	// Commands handed from the front to the back.
	localparam logic [1:0] OP_SINGLE  = 2'd0;
	localparam logic [1:0] OP_METHOD  = 2'd1;
	localparam logic [1:0] OP_SUCCESS = 2'd2;

	// The success burst is ten reply bytes and one completion item.
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] SUCCESS_LAST_STEP = 4'd10;
	localparam logic [STEP_W-1:0] METHOD_ERR_STEP   = 4'd2;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [1:0]  address_type;
		logic [7:0]  address_length;
		logic [15:0] dest_port;
		logic [2:0]  error_code;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

	function automatic logic [7:0] ok_reply_byte(input logic [STEP_W-1:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0:    r = SOCKS_VERSION;
			4'd3:    r = WIRE_IPV4;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ----- src/s5hp_queue.sv -----
module s5hp_queue #(
	parameter int DEPTH = s5hp_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  s5hp_pkg::cmd_t             push_cmd,
	input  logic                       pop,
	output s5hp_pkg::cmd_t             head_cmd,
	output logic                       not_empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] level
);
	import s5hp_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [LW-1:0] FULL_LVL = LW'(DEPTH);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [LW-1:0] level_q;

	assign head_cmd  = slot_q[rd_ptr_q];
	assign not_empty = (level_q != '0);
	assign full      = (level_q == FULL_LVL);
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/s5hp_front.sv -----
module s5hp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           acc,
	input  logic           operation,
	input  logic [7:0]     in_byte,
	output logic           push,
	output s5hp_pkg::cmd_t push_cmd
);
	import s5hp_pkg::*;

	localparam logic [3:0] PH_VER   = 4'd0;
	localparam logic [3:0] PH_NMETH = 4'd1;
	localparam logic [3:0] PH_METH  = 4'd2;
	localparam logic [3:0] PH_RVER  = 4'd3;
	localparam logic [3:0] PH_CMD   = 4'd4;
	localparam logic [3:0] PH_RSV   = 4'd5;
	localparam logic [3:0] PH_ATYP  = 4'd6;
	localparam logic [3:0] PH_DLEN  = 4'd7;
	localparam logic [3:0] PH_ADDR  = 4'd8;
	localparam logic [3:0] PH_PHI   = 4'd9;
	localparam logic [3:0] PH_PLO   = 4'd10;
	localparam logic [3:0] PH_DONE  = 4'd11;
	localparam logic [3:0] PH_ERR   = 4'd12;

	logic [3:0] phase_q, phase_d;
	logic [7:0] byte_count_q, byte_count_d;
	logic [7:0] methods_left_q, methods_left_d;
	logic       no_auth_q, no_auth_d;
	logic [1:0] addr_kind_q, addr_kind_d;
	logic [7:0] addr_len_q, addr_len_d;
	logic [7:0] port_high_q, port_high_d;
	logic       has_result;
	cmd_t       cmd;

	assign push     = acc && !operation && has_result;
	assign push_cmd = cmd;

	always_comb begin
		phase_d        = phase_q;
		byte_count_d   = byte_count_q;
		methods_left_d = methods_left_q;
		no_auth_d      = no_auth_q;
		addr_kind_d    = addr_kind_q;
		addr_len_d     = addr_len_q;
		port_high_d    = port_high_q;
		has_result     = 1'b0;
		cmd            = '0;
		cmd.op         = OP_SINGLE;
		cmd.kind       = KIND_ERROR;

		case (phase_q)
			PH_VER: begin
				if (in_byte != SOCKS_VERSION) begin
					has_result     = 1'b1;
					cmd.error_code = ERR_BAD_VERSION;
					phase_d        = PH_ERR;
				end else begin
					phase_d = PH_NMETH;
				end
			end
			PH_NMETH: begin
				if (in_byte == 8'h00) begin
					has_result     = 1'b1;
					cmd.error_code = ERR_NO_METHODS;
					phase_d        = PH_ERR;
				end else begin
					methods_left_d = in_byte;
					no_auth_d      = 1'b0;
					phase_d        = PH_METH;
				end
			end
			PH_METH: begin
				no_auth_d      = no_auth_q || (in_byte == METHOD_NO_AUTH);
				methods_left_d = methods_left_q - 1'b1;
				if (methods_left_d == 8'h00) begin
					has_result    = 1'b1;
					cmd.op        = OP_METHOD;
					cmd.kind      = KIND_REPLY;
					cmd.data_byte = no_auth_d ? METHOD_NO_AUTH : METHOD_NONE;
					phase_d       = no_auth_d ? PH_RVER : PH_ERR;
				end
			end
			PH_RVER: begin
				if (in_byte != SOCKS_VERSION) begin
					has_result     = 1'b1;
					cmd.error_code = ERR_BAD_REQ_VER;
					phase_d        = PH_ERR;
				end else begin
					phase_d = PH_CMD;
				end
			end
			PH_CMD: begin
				if (in_byte != CMD_CONNECT) begin
					has_result     = 1'b1;
					cmd.error_code = ERR_NOT_CONNECT;
					phase_d        = PH_ERR;
				end else begin
					phase_d = PH_RSV;
				end
			end
			PH_RSV: begin
				if (in_byte != RSV_BYTE) begin
					has_result     = 1'b1;
					cmd.error_code = ERR_RSV_NONZERO;
					phase_d        = PH_ERR;
				end else begin
					phase_d = PH_ATYP;
				end
			end
			PH_ATYP: begin
				byte_count_d = 8'h00;
				if (in_byte == WIRE_IPV4) begin
					addr_kind_d = ATYP_IPV4;
					addr_len_d  = IPV4_LEN;
					phase_d     = PH_ADDR;
				end else if (in_byte == WIRE_DOMAIN) begin
					addr_kind_d = ATYP_DOMAIN;
					phase_d     = PH_DLEN;
				end else if (in_byte == WIRE_IPV6) begin
					addr_kind_d = ATYP_IPV6;
					addr_len_d  = IPV6_LEN;
					phase_d     = PH_ADDR;
				end else begin
					has_result     = 1'b1;
					cmd.error_code = ERR_BAD_ATYP;
					phase_d        = PH_ERR;
				end
			end
			PH_DLEN: begin
				if (in_byte == 8'h00) begin
					has_result     = 1'b1;
					cmd.error_code = ERR_EMPTY_DOMAIN;
					phase_d        = PH_ERR;
				end else begin
					addr_len_d   = in_byte;
					byte_count_d = 8'h00;
					phase_d      = PH_ADDR;
				end
			end
			PH_ADDR: begin
				has_result         = 1'b1;
				cmd.kind           = KIND_ADDR;
				cmd.data_byte      = in_byte;
				cmd.address_type   = addr_kind_q;
				cmd.address_length = addr_len_q;
				byte_count_d       = byte_count_q + 1'b1;
				if (byte_count_d >= addr_len_q) begin
					phase_d = PH_PHI;
				end
			end
			PH_PHI: begin
				port_high_d = in_byte;
				phase_d     = PH_PLO;
			end
			PH_PLO: begin
				has_result         = 1'b1;
				cmd.op             = OP_SUCCESS;
				cmd.kind           = KIND_DONE;
				cmd.address_type   = addr_kind_q;
				cmd.address_length = addr_len_q;
				cmd.dest_port      = {port_high_q, in_byte};
				phase_d            = PH_DONE;
			end
			default: begin
				// Done, error and unused codes swallow the byte.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_VER;
			byte_count_q   <= '0;
			methods_left_q <= '0;
			no_auth_q      <= 1'b0;
			addr_kind_q    <= '0;
			addr_len_q     <= '0;
			port_high_q    <= '0;
		end else if (acc) begin
			if (operation) begin
				phase_q        <= PH_VER;
				byte_count_q   <= '0;
				methods_left_q <= '0;
				no_auth_q      <= 1'b0;
				addr_kind_q    <= '0;
				addr_len_q     <= '0;
				port_high_q    <= '0;
			end else begin
				phase_q        <= phase_d;
				byte_count_q   <= byte_count_d;
				methods_left_q <= methods_left_d;
				no_auth_q      <= no_auth_d;
				addr_kind_q    <= addr_kind_d;
				addr_len_q     <= addr_len_d;
				port_high_q    <= port_high_d;
			end
		end
	end

endmodule

// ----- src/s5hp_back.sv -----
module s5hp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  s5hp_pkg::cmd_t head_cmd,
	input  logic           not_empty,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     kind,
	output logic [7:0]     data_byte,
	output logic [1:0]     address_type,
	output logic [7:0]     address_length,
	output logic [15:0]    dest_port,
	output logic [2:0]     error_code,
	output logic           last
);
	import s5hp_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              advance;
	cmd_t              item;
	logic              item_last;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  data_q;
	logic [1:0]  atyp_q;
	logic [7:0]  alen_q;
	logic [15:0] port_q;
	logic [2:0]  err_q;
	logic        last_q;

	assign advance = not_empty && (!out_valid_q || !out_stall);
	assign pop     = advance && item_last;

	// Expand the command at the head of the queue into its current beat.
	always_comb begin
		item      = head_cmd;
		item_last = 1'b1;
		case (head_cmd.op)
			OP_METHOD: begin
				item            = '0;
				item.kind       = KIND_REPLY;
				if (step_q == '0) begin
					item.data_byte = SOCKS_VERSION;
					item_last      = 1'b0;
				end else if (step_q == METHOD_ERR_STEP) begin
					item.kind       = KIND_ERROR;
					item.error_code = ERR_NO_AUTH;
				end else begin
					item.data_byte = head_cmd.data_byte;
					item_last      = (head_cmd.data_byte == METHOD_NO_AUTH);
				end
			end
			OP_SUCCESS: begin
				if (step_q != SUCCESS_LAST_STEP) begin
					item           = '0;
					item.kind      = KIND_REPLY;
					item.data_byte = ok_reply_byte(step_q);
					item_last      = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				step_q      <= item_last ? '0 : step_q + 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q <= item.kind;
			data_q <= item.data_byte;
			atyp_q <= item.address_type;
			alen_q <= item.address_length;
			port_q <= item.dest_port;
			err_q  <= item.error_code;
			last_q <= item_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign data_byte      = data_q;
	assign address_type   = atyp_q;
	assign address_length = alen_q;
	assign dest_port      = port_q;
	assign error_code     = err_q;
	assign last           = last_q;

endmodule

// ----- src/socks5_handshake_parser_top.sv -----
// Server side of a SOCKS5 handshake restricted to the no-authentication method and the
// CONNECT command. Each input beat is either one client byte or a restart that clears the
// parser for a new connection. A front parser accepts one beat per cycle while the queue
// has room, checks it against the handshake and, when the beat causes results, pushes one
// command into a queue of QUEUE_DEPTH entries. A back expander turns each command into its
// result beats at one beat per cycle unless the receiver stalls, through a registered
// output: one beat for an address byte or an error, two or three for the method reply
// (05 00, or 05 FF followed by the no-auth error), and eleven for the success reply (ten
// reply bytes and a completion beat that carries the address kind, address length and
// big-endian port). The command lands in the queue at the edge that takes the input, and
// the expander registers the first result beat from the queue head. Input is taken every
// cycle while the queue has room, so bytes that cause no result, or a single result,
// stream at one per cycle; the output port moves at most one beat per cycle, so the
// result beats of one byte leave one after another, and a long burst stalls the input
// only once the queue has filled behind it. After an error, or after completion, client
// bytes are dropped without result until a restart beat arrives. The final result beat
// caused by an input carries last.
module socks5_handshake_parser_top #(
	parameter int QUEUE_DEPTH = s5hp_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [1:0]  address_type,
	output logic [7:0]  address_length,
	output logic [15:0] dest_port,
	output logic [2:0]  error_code,
	output logic        last
);
	import s5hp_pkg::*;

	localparam int LW = $clog2(QUEUE_DEPTH + 1);

	logic          acc;
	logic          push;
	logic          pop;
	cmd_t          push_cmd;
	cmd_t          head_cmd;
	logic          not_empty;
	logic          q_full;
	logic [LW-1:0] q_level;

	// The parser holds off only while the command queue is full.
	assign in_stall = q_full;
	assign acc      = in_valid && !in_stall;

	s5hp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.operation(operation),
		.in_byte  (in_byte),
		.push     (push),
		.push_cmd (push_cmd)
	);

	s5hp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.not_empty(not_empty),
		.full     (q_full),
		.level    (q_level)
	);

	s5hp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_cmd      (head_cmd),
		.not_empty     (not_empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.data_byte     (data_byte),
		.address_type  (address_type),
		.address_length(address_length),
		.dest_port     (dest_port),
		.error_code    (error_code),
		.last          (last)
	);

`ifndef SYNTHESIS
	// A completion beat always closes the burst of its input.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_DONE)) |-> last)
		else $error("completion beat without last");

	// An error beat always closes the burst of its input.
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_ERROR)) |-> last)
		else $error("error beat without last");

	// The queue never overfills: a push while full cannot happen.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("command queue overflow");

	// After a push without a pop, the queue level is one higher than before.
	a_level_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (q_level == $past(q_level) + 1'b1))
		else $error("queue level did not follow a push");
`endif

endmodule

// ----- tb/sv/socks5_handshake_parser_top_tb.sv -----
`timescale 1ns / 1ps

// Testbench for the SOCKS5 server handshake parser.
module socks5_handshake_parser_top_tb;
	import s5hp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 64;
	localparam int MAX_REPORTS = 10;

	// Input operations.
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// Reply code for a granted request in the success reply.
	localparam logic [7:0] REPLY_SUCCEEDED = 8'h00;
	// The ten-byte success reply, first byte in the top lane.
	localparam logic [79:0] SUCCESS_REPLY = {SOCKS_VERSION, REPLY_SUCCEEDED, RSV_BYTE,
		WIRE_IPV4, 48'h0};

	// Broken session kinds: the eight error codes, then a session cut short.
	localparam int TRUNCATED   = 8;
	localparam int FAULT_KINDS = TRUNCATED + 1;

	typedef enum logic [3:0] {
		P_GREET_VER,
		P_NMETHODS,
		P_METHODS,
		P_REQ_VER,
		P_COMMAND,
		P_RESERVED,
		P_ADDR_TYPE,
		P_DOMAIN_LEN,
		P_ADDRESS,
		P_PORT_HIGH,
		P_PORT_LOW,
		P_DONE,
		P_FAILED
	} parse_phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [1:0]  address_type;
		logic [7:0]  address_length;
		logic [15:0] dest_port;
		logic [2:0]  error_code;
		logic        last;
	} result_beat_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [1:0]  address_type;
	logic [7:0]  address_length;
	logic [15:0] dest_port;
	logic [2:0]  error_code;
	logic        last;

	// Shadow copy of the parser state.
	parse_phase_t phase_q;
	logic [7:0]   addr_count;
	logic [7:0]   methods_left;
	logic         no_auth_seen;
	logic [1:0]   addr_kind;
	logic [7:0]   addr_len;
	logic [7:0]   port_high;

	// Result beats the parser owes, oldest first.
	result_beat_t owed_beats[$];
	// Client bytes of the session being built.
	logic [7:0]   session_bytes[$];

	int live_beats = 0;
	int error_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fault_turn = 0;
	int broken_sessions = 0;

	socks5_handshake_parser_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.data_byte      (data_byte),
		.address_type   (address_type),
		.address_length (address_length),
		.dest_port      (dest_port),
		.error_code     (error_code),
		.last           (last)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Handshake predictor
	// ------------------------------------------------------------------

	function automatic void reset_parser();
		phase_q = P_GREET_VER;
		addr_count = '0;
		methods_left = '0;
		no_auth_seen = 1'b0;
		addr_kind = '0;
		addr_len = '0;
		port_high = '0;
	endfunction

	function automatic void owe_beat(input logic [1:0] k, input logic [7:0] d,
			input logic [1:0] at, input logic [7:0] al, input logic [15:0] port,
			input logic [2:0] err);
		result_beat_t r;
		r.kind = k;
		r.data_byte = d;
		r.address_type = at;
		r.address_length = al;
		r.dest_port = port;
		r.error_code = err;
		r.last = 1'b0;
		owed_beats.push_back(r);
	endfunction

	// An error beat, after which client bytes are dropped until a restart.
	function automatic void fail_session(input logic [2:0] code);
		owe_beat(KIND_ERROR, 8'h00, '0, 8'h00, 16'h0000, code);
		phase_q = P_FAILED;
	endfunction

	// Advances the shadow parser by one accepted input beat and queues the result
	// beats that it causes.
	function automatic void parse_client_beat(input logic op, input logic [7:0] b);
		int owed_before;
		int i;
		owed_before = owed_beats.size();
		if (op == OP_RESTART) begin
			reset_parser();
			live_beats++;
			return;
		end
		if (phase_q != P_DONE && phase_q != P_FAILED)
			live_beats++;
		case (phase_q)
			P_GREET_VER: begin
				if (b != SOCKS_VERSION)
					fail_session(ERR_BAD_VERSION);
				else
					phase_q = P_NMETHODS;
			end
			P_NMETHODS: begin
				if (b == 8'd0) begin
					fail_session(ERR_NO_METHODS);
				end else begin
					methods_left = b;
					no_auth_seen = 1'b0;
					phase_q = P_METHODS;
				end
			end
			P_METHODS: begin
				if (b == METHOD_NO_AUTH)
					no_auth_seen = 1'b1;
				methods_left = methods_left - 8'd1;
				// The method reply goes out once the whole list is in.
				if (methods_left == 8'd0) begin
					owe_beat(KIND_REPLY, SOCKS_VERSION, '0, 8'h00, 16'h0000, '0);
					owe_beat(KIND_REPLY, no_auth_seen ? METHOD_NO_AUTH : METHOD_NONE,
						'0, 8'h00, 16'h0000, '0);
					if (no_auth_seen)
						phase_q = P_REQ_VER;
					else
						fail_session(ERR_NO_AUTH);
				end
			end
			P_REQ_VER: begin
				if (b != SOCKS_VERSION)
					fail_session(ERR_BAD_REQ_VER);
				else
					phase_q = P_COMMAND;
			end
			P_COMMAND: begin
				if (b != CMD_CONNECT)
					fail_session(ERR_NOT_CONNECT);
				else
					phase_q = P_RESERVED;
			end
			P_RESERVED: begin
				if (b != RSV_BYTE)
					fail_session(ERR_RSV_NONZERO);
				else
					phase_q = P_ADDR_TYPE;
			end
			P_ADDR_TYPE: begin
				addr_count = '0;
				case (b)
					WIRE_IPV4: begin
						addr_kind = ATYP_IPV4;
						addr_len = IPV4_LEN;
						phase_q = P_ADDRESS;
					end
					WIRE_DOMAIN: begin
						addr_kind = ATYP_DOMAIN;
						phase_q = P_DOMAIN_LEN;
					end
					WIRE_IPV6: begin
						addr_kind = ATYP_IPV6;
						addr_len = IPV6_LEN;
						phase_q = P_ADDRESS;
					end
					default: fail_session(ERR_BAD_ATYP);
				endcase
			end
			P_DOMAIN_LEN: begin
				if (b == 8'd0) begin
					fail_session(ERR_EMPTY_DOMAIN);
				end else begin
					addr_len = b;
					addr_count = '0;
					phase_q = P_ADDRESS;
				end
			end
			P_ADDRESS: begin
				owe_beat(KIND_ADDR, b, addr_kind, addr_len, 16'h0000, '0);
				addr_count = addr_count + 8'd1;
				if (addr_count >= addr_len)
					phase_q = P_PORT_HIGH;
			end
			P_PORT_HIGH: begin
				port_high = b;
				phase_q = P_PORT_LOW;
			end
			P_PORT_LOW: begin
				for (i = 0; i < 10; i++)
					owe_beat(KIND_REPLY, SUCCESS_REPLY[79 - 8 * i -: 8], '0, 8'h00,
						16'h0000, '0);
				owe_beat(KIND_DONE, 8'h00, addr_kind, addr_len, {port_high, b}, '0);
				phase_q = P_DONE;
			end
			default: begin
				// Done or failed: the byte is dropped without result.
			end
		endcase
		if (owed_beats.size() > owed_before)
			owed_beats[owed_beats.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Session builders
	// ------------------------------------------------------------------

	function automatic logic [7:0] other_than(input logic [7:0] good);
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == good);
		return v;
	endfunction

	// Greeting with a short method list, now and then a longer one. With no-auth
	// offered the method 00 sits at a random spot; without it every method is nonzero.
	function automatic void add_greeting(input bit offer_no_auth);
		int count;
		int spot;
		int i;
		count = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
		spot = $urandom_range(0, count - 1);
		session_bytes.push_back(SOCKS_VERSION);
		session_bytes.push_back(8'(count));
		for (i = 0; i < count; i++) begin
			if (offer_no_auth && i == spot)
				session_bytes.push_back(METHOD_NO_AUTH);
			else if (offer_no_auth)
				session_bytes.push_back(8'($urandom_range(0, 255)));
			else
				session_bytes.push_back(8'($urandom_range(1, 255)));
		end
	endfunction

	function automatic void add_request_head();
		session_bytes.push_back(SOCKS_VERSION);
		session_bytes.push_back(CMD_CONNECT);
		session_bytes.push_back(RSV_BYTE);
	endfunction

	// Address type, address bytes and port. Domains are mostly short.
	function automatic void add_destination();
		int len;
		int i;
		case ($urandom_range(0, 2))
			0: begin
				session_bytes.push_back(WIRE_IPV4);
				len = IPV4_LEN;
			end
			1: begin
				session_bytes.push_back(WIRE_DOMAIN);
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 64) :
					$urandom_range(1, 8);
				session_bytes.push_back(8'(len));
			end
			default: begin
				session_bytes.push_back(WIRE_IPV6);
				len = IPV6_LEN;
			end
		endcase
		for (i = 0; i < len + 2; i++)
			session_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void add_noise(input int lo, input int hi);
		int n;
		int i;
		n = $urandom_range(lo, hi);
		for (i = 0; i < n; i++)
			session_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void build_good_session();
		add_greeting(1'b1);
		add_request_head();
		add_destination();
		// Bytes after completion are dropped.
		if ($urandom_range(0, 3) == 0)
			add_noise(1, 3);
	endfunction

	// A session that breaks at the point given by the next fault in turn, followed
	// by up to three more bytes, dropped after an error and parsed on in a cut session.
	function automatic void build_broken_session();
		logic [7:0] bad_type;
		int cut;
		case (fault_turn)
			ERR_BAD_VERSION: session_bytes.push_back(other_than(SOCKS_VERSION));
			ERR_NO_METHODS: begin
				session_bytes.push_back(SOCKS_VERSION);
				session_bytes.push_back(8'd0);
			end
			ERR_NO_AUTH: add_greeting(1'b0);
			ERR_BAD_REQ_VER: begin
				add_greeting(1'b1);
				session_bytes.push_back(other_than(SOCKS_VERSION));
			end
			ERR_NOT_CONNECT: begin
				add_greeting(1'b1);
				session_bytes.push_back(SOCKS_VERSION);
				session_bytes.push_back(other_than(CMD_CONNECT));
			end
			ERR_RSV_NONZERO: begin
				add_greeting(1'b1);
				session_bytes.push_back(SOCKS_VERSION);
				session_bytes.push_back(CMD_CONNECT);
				session_bytes.push_back(other_than(RSV_BYTE));
			end
			ERR_BAD_ATYP: begin
				add_greeting(1'b1);
				add_request_head();
				do
					bad_type = 8'($urandom_range(0, 255));
				while (bad_type == WIRE_IPV4 || bad_type == WIRE_DOMAIN ||
					bad_type == WIRE_IPV6);
				session_bytes.push_back(bad_type);
			end
			ERR_EMPTY_DOMAIN: begin
				add_greeting(1'b1);
				add_request_head();
				session_bytes.push_back(WIRE_DOMAIN);
				session_bytes.push_back(8'd0);
			end
			default: begin
				// Cut short: the next restart lands in the middle of the handshake unless only bytes after completion were cut.
				build_good_session();
				cut = $urandom_range(1, session_bytes.size() - 1);
				while (session_bytes.size() > cut)
					void'(session_bytes.pop_back());
			end
		endcase
		add_noise(0, 3);
		broken_sessions++;
		fault_turn = (fault_turn + 1) % FAULT_KINDS;
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Presents one beat from a falling edge and holds it until the rising edge
	// that takes it. Valid stays high across back-to-back beats.
	task automatic send_beat(input logic op, input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		in_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
		parse_client_beat(op, b);
	endtask

	task automatic play_session(input bit with_restart);
		if (with_restart)
			send_beat(OP_RESTART, 8'($urandom_range(0, 255)));
		foreach (session_bytes[i])
			send_beat(OP_BYTE, session_bytes[i]);
		session_bytes.delete();
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// A full IPv4 CONNECT with address bytes at both extremes and port FFFF,
	// then a byte after completion that must be dropped.
	task automatic test_connect_ipv4_extremes();
		session_bytes = '{SOCKS_VERSION, 8'd1, METHOD_NO_AUTH,
			SOCKS_VERSION, CMD_CONNECT, RSV_BYTE, WIRE_IPV4,
			8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hA5};
		play_session(1'b1);
	endtask

	// A bad greeting version with a byte after the error, then a method list
	// without no-auth, which answers 05 FF before the error beat.
	task automatic test_greeting_failures();
		session_bytes = '{8'hFF, SOCKS_VERSION};
		play_session(1'b1);
		session_bytes = '{SOCKS_VERSION, 8'd2, 8'hFF, 8'h01};
		play_session(1'b1);
	endtask

	// A longer method list with no-auth as its very last entry, then a domain
	// name and port 0000.
	task automatic test_long_lists();
		int i;
		session_bytes.push_back(SOCKS_VERSION);
		session_bytes.push_back(8'd5);
		for (i = 0; i < 4; i++)
			session_bytes.push_back(8'($urandom_range(1, 255)));
		session_bytes.push_back(METHOD_NO_AUTH);
		add_request_head();
		session_bytes.push_back(WIRE_DOMAIN);
		session_bytes.push_back(8'd8);
		for (i = 0; i < 8; i++)
			session_bytes.push_back(8'($urandom_range(0, 255)));
		session_bytes.push_back(8'h00);
		session_bytes.push_back(8'h00);
		play_session(1'b1);
	endtask

	// Random sessions: two broken ones, then a good one, now and then plain noise
	// in its place. With cover_faults the run keeps going with broken sessions
	// only, once the budget is spent, until every kind has been played once.
	task automatic test_random_sessions(input int budget, input bit cover_faults);
		int start;
		int slot;
		start = live_beats;
		slot = 0;
		while (live_beats - start < budget ||
				(cover_faults && broken_sessions < FAULT_KINDS)) begin
			if (slot != 2 || live_beats - start >= budget) begin
				build_broken_session();
				play_session(1'b1);
			end else if ($urandom_range(0, 9) == 0) begin
				add_noise(1, 8);
				play_session(1'($urandom_range(0, 1)));
			end else begin
				build_good_session();
				play_session(1'b1);
			end
			slot = (slot + 1) % 3;
		end
	endtask

	// ------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------

	// Receiver back-pressure, decided afresh every cycle.
	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

	// Every beat taken from the output is compared with the oldest owed beat.
	always @(posedge clk) begin : check_results
		result_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_beats.size() == 0) begin
				if (error_count < MAX_REPORTS)
					$display("unexpected result beat at cycle %0d: kind=%0d data=%02h",
						cycle_count, kind, data_byte);
				error_count++;
			end else begin
				want = owed_beats.pop_front();
				if (kind !== want.kind || data_byte !== want.data_byte ||
						address_type !== want.address_type ||
						address_length !== want.address_length ||
						dest_port !== want.dest_port || error_code !== want.error_code ||
						last !== want.last) begin
					if (error_count < MAX_REPORTS) begin
						$display("result mismatch at cycle %0d", cycle_count);
						$display({"  expected kind=%0d data=%02h atyp=%0d alen=%0d",
							" port=%04h err=%0d last=%0d"},
							want.kind, want.data_byte, want.address_type,
							want.address_length, want.dest_port, want.error_code, want.last);
						$display({"  actual   kind=%0d data=%02h atyp=%0d alen=%0d",
							" port=%04h err=%0d last=%0d"},
							kind, data_byte, address_type, address_length, dest_port,
							error_code, last);
					end
					error_count++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		in_valid = 1'b0;
		operation = OP_BYTE;
		in_byte = 8'h00;
		out_stall = 1'b0;
		arst_n = 1'b0;
		reset_parser();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Sender idles rarely, receiver stalls most of the time.
		send_idle_pct = 12;
		recv_idle_pct = 74;
		test_connect_ipv4_extremes();
		test_greeting_failures();
		test_random_sessions(4, 1'b0);

		// The other way round.
		send_idle_pct = 74;
		recv_idle_pct = 12;
		test_long_lists();
		test_random_sessions(10, 1'b0);

		// Full rate on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_sessions(20, 1'b1);

		@(negedge clk);
		in_valid <= 1'b0;
		while (owed_beats.size() != 0)
			@(posedge clk);
		// Anything the parser emits now is a beat nobody asked for.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
